// ----- design/rmst_pkg.sv -----
package rmst_pkg;

  localparam int LEAF_SLOTS = 1024;
  localparam int LEAF_W     = $clog2(LEAF_SLOTS);
  localparam int NODE_W     = LEAF_W + 1;
  localparam int POS_W      = 10;
  localparam int VAL_W      = 30;

  localparam logic [VAL_W-1:0] CAP_VALUE  = VAL_W'(1000000000);
  localparam logic [VAL_W-1:0] FILL_VALUE = VAL_W'(32'h3f3f3f3f);

  localparam logic [POS_W-1:0] POS_MIN = POS_W'(1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(LEAF_SLOTS - 2);

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_REBUILD = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RB_READ,
    ST_RB_WRITE,
    ST_Q_WALK,
    ST_Q_DONE
  } state_t;

  function automatic logic [VAL_W-1:0] min_val(input logic [VAL_W-1:0] x,
                                               input logic [VAL_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

endpackage

// ----- design/range_min_segment_tree.sv -----
// Range-minimum segment tree over 1024 leaf slots, held in one 2048-word memory.
// Input channel (in_valid / in_stall) carries one action per item:
//   write   - stores in_leaf_value in leaf in_leaf_index.
//   rebuild - recomputes internal nodes 1023 down to 1; each node takes a single
//             read/write pair, ST_RB_READ then ST_RB_WRITE.
//   query   - minimum over leaves range_low..range_high (clamped to 1..1022),
//             never above 1000000000. Both ends climb the tree together; each
//             level issues two memory reads and folds them in the next cycle, and a
//             query holds the input until its result is loaded into the output register.
//   code 3  - ignored.
// Only a query gives an item on the result channel (out_valid / out_stall).
// The result sits in an output register, so the next action is taken while it
// waits; a later query holds in its final state until that register is free.
// in_stall stays high while an action is at work.
// After reset a clearing pass writes 0x3f3f3f3f to all 2048 words, one a
// cycle; in_stall is high until the pass ends.
module range_min_segment_tree (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [9:0]  in_leaf_index,
  input  logic [29:0] in_leaf_value,
  input  logic [9:0]  in_range_low,
  input  logic [9:0]  in_range_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [29:0] out_range_min
);

  localparam int NW = rmst_pkg::NODE_W;
  localparam int LW = rmst_pkg::LEAF_W;
  localparam int VW = rmst_pkg::VAL_W;

  logic [VW-1:0] mem [rmst_pkg::LEAF_SLOTS*2];

  rmst_pkg::state_t state_r, state_nxt;
  logic [NW-1:0]    clr_r, clr_nxt;
  logic [LW-1:0]    rb_i_r, rb_i_nxt;
  logic [NW-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [VW-1:0]    acc_r, acc_nxt;
  logic             take_a_r, take_a_nxt, take_b_r, take_b_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VW-1:0]    out_min_r, out_min_nxt;
  logic [VW-1:0]    rd_a_r, rd_b_r;

  logic             mem_we;
  logic [NW-1:0]    mem_waddr, rd_addr_a, rd_addr_b;
  logic [VW-1:0]    mem_wdata;

  logic                    in_acc;
  rmst_pkg::action_t       act;
  logic [9:0]              lo_c, hi_c;
  logic                    walk_go;
  logic [VW-1:0]           cand_a, cand_b, pair_min;

  assign in_stall      = (state_r != rmst_pkg::ST_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign act           = rmst_pkg::action_t'(in_action);
  assign out_valid     = out_valid_r;
  assign out_range_min = out_min_r;

  always_comb begin
    lo_c = in_range_low;
    if (in_range_low < rmst_pkg::POS_MIN) lo_c = rmst_pkg::POS_MIN;
    else if (in_range_low > rmst_pkg::POS_MAX) lo_c = rmst_pkg::POS_MAX;
    hi_c = in_range_high;
    if (in_range_high < rmst_pkg::POS_MIN) hi_c = rmst_pkg::POS_MIN;
    else if (in_range_high > rmst_pkg::POS_MAX) hi_c = rmst_pkg::POS_MAX;
  end

  // Shared compare unit: rebuild takes the plain pair, a query masks untaken reads.
  assign walk_go  = ((a_r ^ b_r) != NW'(1)) && (a_r < b_r);
  assign cand_a   = (state_r == rmst_pkg::ST_Q_WALK && !take_a_r) ? rmst_pkg::CAP_VALUE
                                                                  : rd_a_r;
  assign cand_b   = (state_r == rmst_pkg::ST_Q_WALK && !take_b_r) ? rmst_pkg::CAP_VALUE
                                                                  : rd_b_r;
  assign pair_min = rmst_pkg::min_val(cand_a, cand_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmst_pkg::ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rb_i_r    <= rb_i_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    acc_r     <= acc_nxt;
    take_a_r  <= take_a_nxt;
    take_b_r  <= take_b_nxt;
    out_min_r <= out_min_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    rb_i_nxt      = rb_i_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    take_a_nxt    = take_a_r;
    take_b_nxt    = take_b_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_min_nxt   = out_min_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = rmst_pkg::FILL_VALUE;
    rd_addr_a     = a_r ^ NW'(1);
    rd_addr_b     = b_r ^ NW'(1);

    unique case (state_r)
      rmst_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + NW'(1);
        if (clr_r == '1) state_nxt = rmst_pkg::ST_IDLE;
      end

      rmst_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (act)
            rmst_pkg::ACT_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = {1'b1, in_leaf_index[LW-1:0]};
              mem_wdata = in_leaf_value;
            end
            rmst_pkg::ACT_REBUILD: begin
              rb_i_nxt  = '1;
              state_nxt = rmst_pkg::ST_RB_READ;
            end
            rmst_pkg::ACT_QUERY: begin
              acc_nxt  = rmst_pkg::CAP_VALUE;
              pend_nxt = 1'b0;
              if (lo_c > hi_c) begin
                // empty range: no climb, answer stays at the cap
                a_nxt = '0;
                b_nxt = '0;
              end else begin
                a_nxt = NW'(lo_c) + NW'(rmst_pkg::LEAF_SLOTS - 1);
                b_nxt = NW'(hi_c) + NW'(rmst_pkg::LEAF_SLOTS + 1);
              end
              state_nxt = rmst_pkg::ST_Q_WALK;
            end
            rmst_pkg::ACT_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end

      rmst_pkg::ST_RB_READ: begin
        rd_addr_a = {rb_i_r, 1'b0};
        rd_addr_b = {rb_i_r, 1'b1};
        state_nxt = rmst_pkg::ST_RB_WRITE;
      end

      rmst_pkg::ST_RB_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = NW'(rb_i_r);
        mem_wdata = pair_min;
        if (rb_i_r == LW'(1)) begin
          state_nxt = rmst_pkg::ST_IDLE;
        end else begin
          rb_i_nxt  = rb_i_r - LW'(1);
          state_nxt = rmst_pkg::ST_RB_READ;
        end
      end

      rmst_pkg::ST_Q_WALK: begin
        // fold the reads issued last cycle while issuing the next level
        if (pend_r) acc_nxt = rmst_pkg::min_val(acc_r, pair_min);
        if (walk_go) begin
          take_a_nxt = !a_r[0];
          take_b_nxt = b_r[0];
          a_nxt      = a_r >> 1;
          b_nxt      = b_r >> 1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = rmst_pkg::ST_Q_DONE;
        end
      end

      rmst_pkg::ST_Q_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = acc_r;
          state_nxt     = rmst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rmst_pkg::ST_IDLE;
      end
    endcase
  end

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_min_r <= rmst_pkg::CAP_VALUE))
    else $error("result above cap");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rmst_pkg::ST_Q_DONE))
    else $error("result loaded outside query completion");

  a_rb_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmst_pkg::ST_RB_READ || state_r == rmst_pkg::ST_RB_WRITE)
      |-> (rb_i_r != '0))
    else $error("rebuild reached node zero");

  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == rmst_pkg::ST_Q_WALK))
    else $error("pending query read outside walk");

endmodule
